>>> src/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// shared types and constants of the fixed-point alu
// ----------------------------------------------------------------------------
package fpa_pkg;

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_MUL   = 4'd2,
    CMD_DIV   = 4'd3,
    CMD_EQ    = 4'd4,
    CMD_NE    = 4'd5,
    CMD_GT    = 4'd6,
    CMD_LT    = 4'd7,
    CMD_GE    = 4'd8,
    CMD_LE    = 4'd9,
    CMD_MIN   = 4'd10,
    CMD_MAX   = 4'd11,
    CMD_INC   = 4'd12,
    CMD_DEC   = 4'd13,
    CMD_TOINT = 4'd14,
    CMD_NONE  = 4'd15
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  localparam int unsigned DATA_W = 32;

endpackage

>>> src/fpa_in_if.sv
// ----------------------------------------------------------------------------
// fpa_in_if
// operation channel: valid, ready, command and two raw operands
// ----------------------------------------------------------------------------
interface fpa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         cmd;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

>>> src/fpa_out_if.sv
// ----------------------------------------------------------------------------
// fpa_out_if
// result channel: valid, ready, value, truth bit and status
// ----------------------------------------------------------------------------
interface fpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               truth;
  logic [1:0]         status;

  modport source (output valid, value, truth, status, input ready);
  modport sink   (input valid, value, truth, status, output ready);
endinterface

>>> src/fpa_div.sv
// ----------------------------------------------------------------------------
// fpa_div
// pipelined restoring divider, one quotient bit per stage, stall by enable
// ----------------------------------------------------------------------------
module fpa_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  logic [NW-1:0] q_r   [NW+1];
  logic [DW:0]   rm_r  [NW+1];
  logic [DW-1:0] d_r   [NW+1];

  assign q_r[0]  = num;
  assign rm_r[0] = '0;
  assign d_r[0]  = den;

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    logic [NW-1:0] qs_r;
    logic [DW:0]   rs_r;
    logic [DW-1:0] ds_r;
    assign sh = {rm_r[i], q_r[i][NW-1]};
    assign df = sh - {2'b0, d_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        qs_r <= {q_r[i][NW-2:0], ~df[DW+1]};
        rs_r <= df[DW+1] ? sh[DW:0] : df[DW:0];
        ds_r <= d_r[i];
      end
    end
    assign q_r[i+1]  = qs_r;
    assign rm_r[i+1] = rs_r;
    assign d_r[i+1]  = ds_r;
  end

  assign quo = q_r[NW];
  assign rem = rm_r[NW][DW-1:0];

endmodule

>>> src/fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// signed fixed-point alu, pipelined, when not stalled one operation per cycle
// ----------------------------------------------------------------------------
// Accepts one operation every cycle while the pipe advances and returns each
// result in order, after a pipe depth set by the divider, which resolves one
// quotient bit per stage. Multiply is split into four 16x16 partial products.
// The whole pipe advances together: it moves whenever the output register is
// empty or its result is transferred.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu #(
  parameter int unsigned FRAC_BITS = 8
) (
  input logic  clk,
  input logic  rst_n,
  fpa_in_if.sink    in_ch,
  fpa_out_if.source out_ch
);

  localparam int unsigned W  = fpa_pkg::DATA_W;
  localparam int unsigned NW = W + FRAC_BITS + 1;
  localparam int unsigned DL = NW;

  logic adv;
  assign adv = ~out_ch.valid | out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: decode, magnitudes, partial products, simple ops
  fpa_pkg::cmd_t cmd_w;
  logic          sa, sb;
  logic [W-1:0]  ma, mb;
  assign cmd_w = fpa_pkg::cmd_t'(in_ch.cmd);
  assign sa = in_ch.operand_a[W-1];
  assign sb = in_ch.operand_b[W-1];
  assign ma = sa ? W'(-in_ch.operand_a) : W'(in_ch.operand_a);
  assign mb = sb ? W'(-in_ch.operand_b) : W'(in_ch.operand_b);

  logic [W-1:0] sval;
  logic         struth;
  logic         lt, eqv;
  assign lt  = in_ch.operand_a < in_ch.operand_b;
  assign eqv = in_ch.operand_a == in_ch.operand_b;

  always_comb begin
    sval   = '0;
    struth = 1'b0;
    unique case (cmd_w)
      fpa_pkg::CMD_ADD:   sval = W'(in_ch.operand_a + in_ch.operand_b);
      fpa_pkg::CMD_SUB:   sval = W'(in_ch.operand_a - in_ch.operand_b);
      fpa_pkg::CMD_EQ:    struth = eqv;
      fpa_pkg::CMD_NE:    struth = ~eqv;
      fpa_pkg::CMD_GT:    struth = ~lt & ~eqv;
      fpa_pkg::CMD_LT:    struth = lt;
      fpa_pkg::CMD_GE:    struth = ~lt;
      fpa_pkg::CMD_LE:    struth = lt | eqv;
      fpa_pkg::CMD_MIN:   sval = lt ? in_ch.operand_a : in_ch.operand_b;
      fpa_pkg::CMD_MAX:   sval = (~lt & ~eqv) ? in_ch.operand_a : in_ch.operand_b;
      fpa_pkg::CMD_INC:   sval = W'(in_ch.operand_a + 1);
      fpa_pkg::CMD_DEC:   sval = W'(in_ch.operand_a - 1);
      fpa_pkg::CMD_TOINT: sval = W'(in_ch.operand_a >>> FRAC_BITS);
      default:            sval = '0;
    endcase
  end

  logic          v1_r;
  fpa_pkg::cmd_t c1_r;
  logic          neg1_r, bz1_r, t1_r;
  logic [W-1:0]  s1_r;
  logic [2*W-1:0] pll_r, plh_r, phl_r, phh_r;
  logic [NW-1:0] dn1_r;
  logic [W-1:0]  dd1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r   <= cmd_w;
      neg1_r <= sa ^ sb;
      bz1_r  <= in_ch.operand_b == '0;
      t1_r   <= struth;
      s1_r   <= sval;
      pll_r  <= (2*W)'(ma[15:0]) * (2*W)'(mb[15:0]);
      plh_r  <= ((2*W)'(ma[15:0]) * (2*W)'(mb[W-1:16])) << 16;
      phl_r  <= ((2*W)'(ma[W-1:16]) * (2*W)'(mb[15:0])) << 16;
      phh_r  <= ((2*W)'(ma[W-1:16]) * (2*W)'(mb[W-1:16])) << W;
      // 2*|a|*2^F + |b|, divided by 2*|b|
      dn1_r  <= NW'({ma, {FRAC_BITS{1'b0}}, 1'b0}) + NW'(mb);
      dd1_r  <= mb;
    end
  end

  // stage 2: multiply sum, round
  logic [2*W-1:0] mq;
  assign mq   = (pll_r + plh_r + phl_r + phh_r + ((2*W)'(1) << (FRAC_BITS-1)))
                >> FRAC_BITS;

  // divider runs from stage 1; 2*b fits 33 bits, quotient bit by bit
  logic [NW-1:0] dq;
  logic [W:0]    dr_unused;
  fpa_div #(.NW(NW), .DW(W+1)) u_div (
    .clk (clk),
    .en  (adv),
    .num (dn1_r),
    .den ({dd1_r, 1'b0}),
    .quo (dq),
    .rem (dr_unused)
  );

  // side pipe for the control and the multiply result
  logic          vp_r  [DL+1];
  fpa_pkg::cmd_t cp_r  [DL+1];
  logic          np_r  [DL+1];
  logic          zp_r  [DL+1];
  logic          tp_r  [DL+1];
  logic [W-1:0]  sp_r  [DL+1];
  logic [2*W-1:0] mp_r [DL+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DL; i++) vp_r[i] <= 1'b0;
    end else if (adv) begin
      vp_r[0] <= v1_r;
      for (int i = 1; i <= DL; i++) vp_r[i] <= vp_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cp_r[0] <= c1_r;
      np_r[0] <= neg1_r;
      zp_r[0] <= bz1_r;
      tp_r[0] <= t1_r;
      sp_r[0] <= s1_r;
      mp_r[0] <= mq;
      for (int i = 1; i <= DL; i++) begin
        cp_r[i] <= cp_r[i-1];
        np_r[i] <= np_r[i-1];
        zp_r[i] <= zp_r[i-1];
        tp_r[i] <= tp_r[i-1];
        sp_r[i] <= sp_r[i-1];
        mp_r[i] <= mp_r[i-1];
      end
    end
  end

  // final stage: select, sign and saturate
  logic [2*W-1:0] q;
  logic           ng;
  logic [W-1:0]   fval;
  logic           ftruth;
  logic [1:0]     fst;

  assign ng = np_r[DL-1];
  assign q  = (cp_r[DL-1] == fpa_pkg::CMD_MUL) ? mp_r[DL-1] : (2*W)'(dq);

  always_comb begin
    fval   = sp_r[DL-1];
    ftruth = tp_r[DL-1];
    fst    = fpa_pkg::ST_OK;
    if (cp_r[DL-1] == fpa_pkg::CMD_MUL || cp_r[DL-1] == fpa_pkg::CMD_DIV) begin
      if (cp_r[DL-1] == fpa_pkg::CMD_DIV && zp_r[DL-1]) begin
        fval = '0;
        fst  = fpa_pkg::ST_DIV0;
      end else if (ng) begin
        if (q > (2*W)'(33'h0_8000_0000)) begin
          fval = {1'b1, {(W-1){1'b0}}};
          fst  = fpa_pkg::ST_SAT;
        end else begin
          fval = W'(-q);
        end
      end else begin
        if (q > (2*W)'(33'h0_7fff_ffff)) begin
          fval = {1'b0, {(W-1){1'b1}}};
          fst  = fpa_pkg::ST_SAT;
        end else begin
          fval = q[W-1:0];
        end
      end
    end
  end

  logic         ov_r;
  logic [W-1:0] oval_r;
  logic         otr_r;
  logic [1:0]   ost_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= vp_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oval_r <= fval;
      otr_r  <= ftruth;
      ost_r  <= fst;
    end
  end

  assign out_ch.valid  = ov_r;
  assign out_ch.value  = oval_r;
  assign out_ch.truth  = otr_r;
  assign out_ch.status = ost_r;

  logic unused_ok;
  assign unused_ok = ^{dr_unused, vp_r[DL], cp_r[DL], np_r[DL], zp_r[DL],
                       tp_r[DL], sp_r[DL], mp_r[DL]};

endmodule

>>> tb/sv/fpa_alu_checker.sv
// ----------------------------------------------------------------------------
// fpa_alu_checker
// watches both channels, predicts each alu result and compares it in order
// ----------------------------------------------------------------------------
module fpa_alu_checker #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic    clk,
  input  logic    rst_n,
  fpa_in_if       in_mon,
  fpa_out_if      out_mon,
  output int      fail_count,
  output int      pending
);

  typedef struct packed {
    logic [31:0] value;
    logic        truth;
    logic [1:0]  status;
  } alu_res_t;

  alu_res_t result_q[$];

  localparam logic [63:0] POS_LIM = 64'h7FFF_FFFF;
  localparam logic [63:0] NEG_LIM = 64'h8000_0000;

  function automatic logic [31:0] sat_sign(input logic neg, input logic [63:0] q,
                                           inout logic [1:0] st);
    if (neg) begin
      if (q > NEG_LIM) begin
        st = fpa_pkg::ST_SAT;
        return NEG_LIM[31:0];
      end
      return 32'(64'd0 - q);
    end
    if (q > POS_LIM) begin
      st = fpa_pkg::ST_SAT;
      return POS_LIM[31:0];
    end
    return q[31:0];
  endfunction

  function automatic alu_res_t alu_predict(input logic [3:0] cmd,
                                           input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    alu_res_t r;
    logic [63:0] ma, mb, m, q, n;
    logic neg;
    r = '0;
    ma = a < 0 ? 64'(-64'(a)) : 64'(a);
    mb = b < 0 ? 64'(-64'(b)) : 64'(b);
    neg = (a < 0) != (b < 0);
    case (cmd)
      fpa_pkg::CMD_ADD: r.value = a + b;
      fpa_pkg::CMD_SUB: r.value = a - b;
      fpa_pkg::CMD_MUL: begin
        m = ma * mb;
        q = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        r.value = sat_sign(neg, q, r.status);
      end
      fpa_pkg::CMD_DIV: begin
        if (b == 0) r.status = fpa_pkg::ST_DIV0;
        else begin
          n = ma << FRAC_BITS;
          q = (2 * n + mb) / (2 * mb);
          r.value = sat_sign(neg, q, r.status);
        end
      end
      fpa_pkg::CMD_EQ: r.truth = a == b;
      fpa_pkg::CMD_NE: r.truth = a != b;
      fpa_pkg::CMD_GT: r.truth = a > b;
      fpa_pkg::CMD_LT: r.truth = a < b;
      fpa_pkg::CMD_GE: r.truth = a >= b;
      fpa_pkg::CMD_LE: r.truth = a <= b;
      fpa_pkg::CMD_MIN: r.value = a < b ? a : b;
      fpa_pkg::CMD_MAX: r.value = a > b ? a : b;
      fpa_pkg::CMD_INC: r.value = a + 1;
      fpa_pkg::CMD_DEC: r.value = a - 1;
      fpa_pkg::CMD_TOINT: r.value = a >>> FRAC_BITS;
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    alu_res_t exp_r;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        result_q.push_back(alu_predict(in_mon.cmd, in_mon.operand_a, in_mon.operand_b));
      if (out_mon.valid && out_mon.ready) begin
        if (result_q.size() == 0) report_mismatch("result with none expected");
        else begin
          exp_r = result_q.pop_front();
          if (out_mon.value !== exp_r.value)
            report_mismatch($sformatf("value %h, expected %h", out_mon.value, exp_r.value));
          if (out_mon.truth !== exp_r.truth)
            report_mismatch($sformatf("truth %b, expected %b", out_mon.truth, exp_r.truth));
          if (out_mon.status !== exp_r.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_mon.status,
                                      exp_r.status));
        end
      end
    end
    pending <= result_q.size();
  end
endmodule

>>> tb/sv/fixed_point_q24_8_alu_tb.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_tb
// directed corner operations then random traffic with random idle bursts on
// both channels; results are checked in order by the checker
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_tb;

  localparam int LATENCY = 42;
  localparam int N_RANDOM = 1450;
  localparam int WATCHDOG = 2000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   tail_phase;

  fpa_in_if  in_ch ();
  fpa_out_if out_ch ();

  fixed_point_q24_8_alu u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  fpa_alu_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.cmd       = '0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready    = 1'b0;
    tail_phase      = 1'b0;
  end

  // result side stalls in bursts
  always @(posedge clk) begin
    int stall;
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (!tail_phase && $urandom_range(0, 15) == 0) begin
      stall = $urandom_range(1, 11);
      out_ch.ready <= 1'b0;
      repeat (stall) @(posedge clk);
      out_ch.ready <= 1'b1;
    end else out_ch.ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles >= WATCHDOG) begin
      $display("fixed_point_q24_8_alu regression: fail");
      $finish;
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 4095)) - 2048);
      3: return 32'($signed($urandom_range(0, 65535)) - 32768);
      4: return 32'd0;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_op(input logic [3:0] cmd, input logic [31:0] a, input logic [31:0] b,
                         input bit idling);
    int gap;
    if (idling && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial begin
    int i;
    logic [3:0] op;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i <= fpa_pkg::CMD_NONE; i++) begin
      send_op(i[3:0], 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    end
    send_op(fpa_pkg::CMD_DIV, 32'h0000_0500, 32'd0, 1'b0);
    send_op(fpa_pkg::CMD_DIV, 32'h7FFF_FFFF, 32'd1, 1'b0);
    send_op(fpa_pkg::CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_op(fpa_pkg::CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_op(fpa_pkg::CMD_MUL, 32'hFFFF_FF80, 32'h0000_0001, 1'b0);
    send_op(fpa_pkg::CMD_MUL, 32'h0000_0080, 32'h0000_0001, 1'b0);
    send_op(fpa_pkg::CMD_DIV, 32'd1, 32'd512, 1'b0);
    send_op(fpa_pkg::CMD_TOINT, 32'hFFFF_FFFF, 32'd0, 1'b0);
    send_op(fpa_pkg::CMD_EQ, 32'd5, 32'd5, 1'b0);

    // hold off until everything has drained
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 150) tail_phase = 1'b1;
      op = 4'($urandom_range(0, 15));
      send_op(op, pick_operand(), pick_operand(), !tail_phase);
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0) $display("fixed_point_q24_8_alu regression: pass");
    else $display("fixed_point_q24_8_alu regression: fail");
    $finish;
  end
endmodule
